// ===== design/sta_pkg.sv =====
`timescale 1ns / 1ps

package sta_pkg;

  // Operation codes carried on the mode field.
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_GET     = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Field widths.
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 8;
  localparam int VALUE_W = 32;
  localparam int SIZE_W  = 7;
  localparam int GRANT_W = 6;
  localparam int STAT_W  = 2;

  // Size register value after reset.
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture a transaction and start the slot read
    logic execute;   // perform the operation and load the result register
  } sta_cmd_t;

endpackage

// ===== design/sta_ctrl.sv =====
`timescale 1ns / 1ps

module sta_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output sta_pkg::sta_cmd_t cmd
);
  import sta_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // A new transaction is taken only in the idle state.
  assign in_ready    = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ready;
  assign cmd.load_in = in_valid && in_ready;
  assign cmd.execute = (state_r == S_EXEC) && out_free;
  assign out_valid   = out_valid_r;

  // Next state and result-valid logic.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load_in) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.execute) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/sta_dp.sv =====
`timescale 1ns / 1ps

module sta_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sta_pkg::sta_cmd_t             cmd,
  input  logic                          cfg_we,
  input  logic [sta_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic [sta_pkg::MODE_W-1:0]    in_mode,
  input  logic signed [sta_pkg::INDEX_W-1:0] in_slot_index,
  input  logic [sta_pkg::VALUE_W-1:0]   in_object_value,
  output logic [sta_pkg::STAT_W-1:0]    out_status,
  output logic [sta_pkg::GRANT_W-1:0]   out_granted_index,
  output logic [sta_pkg::VALUE_W-1:0]   out_read_value
);
  import sta_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  // Slot storage; occupancy bits mark nonzero slots and reset clears them.
  logic [VALUE_W-1:0]     mem [TABLE_DEPTH];
  logic [VALUE_W-1:0]     mem_q;
  logic [TABLE_DEPTH-1:0] occ_r, occ_nxt;
  logic [SIZE_W-1:0]      size_r;

  // Captured transaction.
  logic [MODE_W-1:0]  mode_r;
  logic [INDEX_W-1:0] sidx_r;
  logic [VALUE_W-1:0] val_r;

  // Result registers.
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [GRANT_W-1:0] grant_r, grant_nxt;
  logic [VALUE_W-1:0] rdata_r, rdata_nxt;

  logic [7:0]       eff_size;
  logic             in_range;
  logic [IDX_W-1:0] slot;
  logic             found;
  logic [IDX_W-1:0] free_idx;
  logic [7:0]       free_w;
  logic             do_write;

  // Effective size is the register saturated to the table depth.
  assign eff_size = ({1'b0, size_r} > 8'(TABLE_DEPTH)) ? 8'(TABLE_DEPTH)
                                                       : {1'b0, size_r};
  assign in_range = !sidx_r[INDEX_W-1] && ({1'b0, sidx_r[INDEX_W-2:0]} < eff_size);
  assign slot     = sidx_r[IDX_W-1:0];

  // Lowest empty slot below the effective size.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!occ_r[i] && (8'(i) < eff_size)) begin
        found    = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign free_w = 8'(free_idx);

  // Operation decode and result formation.
  always_comb begin
    status_nxt = ST_OK;
    grant_nxt  = '0;
    rdata_nxt  = '0;
    occ_nxt    = occ_r;
    do_write   = 1'b0;
    unique case (mode_r)
      MODE_ALLOC: begin
        if (found) begin
          grant_nxt         = free_w[GRANT_W-1:0];
          occ_nxt[free_idx] = (val_r != '0);
          do_write          = 1'b1;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      MODE_GET: begin
        if (in_range) begin
          rdata_nxt = occ_r[slot] ? mem_q : '0;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      MODE_RELEASE: begin
        if (in_range) begin
          occ_nxt[slot] = 1'b0;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  // Slot memory: read at capture, write on allocate.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mem_q <= mem[in_slot_index[IDX_W-1:0]];
    end
    if (cmd.execute && do_write) begin
      mem[free_idx] <= val_r;
    end
  end

  // Control state: occupancy and size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      size_r <= SIZE_RESET;
    end else begin
      if (cmd.execute) begin
        occ_r <= occ_nxt;
      end
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode;
      sidx_r <= in_slot_index;
      val_r  <= in_object_value;
    end
    if (cmd.execute) begin
      status_r <= status_nxt;
      grant_r  <= grant_nxt;
      rdata_r  <= rdata_nxt;
    end
  end

  assign out_status        = status_r;
  assign out_granted_index = grant_r;
  assign out_read_value    = rdata_r;

endmodule

// ===== design/slot_table_allocator.sv =====
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     in_valid / in_ready    in_mode, in_slot_index, in_object_value
// result    out_valid / out_ready  out_status, out_granted_index, out_read_value
// config    cfg_we                 cfg_wdata (table size)
//
// Each transaction's capture cycle starts the slot read; the execute state then runs
// the free-slot search and the memory write and loads the result register.
// Reset (rst_n, synchronous) clears all occupancy bits and sets the size to 64.
// A held result stalls the execute state; no new transaction is taken meanwhile.

module slot_table_allocator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_mode,
  input  logic signed [7:0]    in_slot_index,
  input  logic [31:0]          in_object_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [5:0]           out_granted_index,
  output logic [31:0]          out_read_value,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_wdata
);
  import sta_pkg::*;

  sta_cmd_t cmd;

  // Sequencing and handshakes.
  sta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Slot storage, search and result registers.
  sta_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_mode           (in_mode),
    .in_slot_index     (in_slot_index),
    .in_object_value   (in_object_value),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_read_value    (out_read_value)
  );

endmodule

// ===== verif/slot_table_allocator_tb.sv =====
`timescale 1ns / 1ps

module slot_table_allocator_tb;
  import sta_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  // The mode encoding that the block treats as a no-op.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 6;

  typedef struct {
    logic [1:0]        mode;
    logic signed [7:0] slot_index;
    logic [31:0]       handle;
  } slot_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  granted;
    logic [31:0] value;
  } slot_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = '0;
  logic signed [7:0] in_slot_index = '0;
  logic [31:0] in_object_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [5:0] out_granted_index;
  logic [31:0] out_read_value;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  // Scoreboard state and the shadow copy of the handle table.
  slot_req_t    pending_reqs[$];
  slot_result_t expected_results[$];
  logic [31:0]  handle_table[TABLE_DEPTH];
  logic [6:0]   table_size_model = SIZE_RESET;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;

  slot_table_allocator #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_slot_index(in_slot_index),
    .in_object_value(in_object_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_granted_index(out_granted_index),
    .out_read_value(out_read_value),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Number of slots actually in use, after saturating the size to the depth.
  function automatic int active_slots();
    return (table_size_model > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_size_model);
  endfunction

  // Applies one operation to the shadow table and returns what the block must report.
  function automatic slot_result_t apply_slot_op(logic [1:0] mode, logic signed [7:0] idx,
                                                 logic [31:0] handle);
    slot_result_t res;
    int n;
    bit in_range;
    n = active_slots();
    res.status = ST_OK;
    res.granted = '0;
    res.value = '0;
    in_range = !idx[7] && (int'(idx) < n);
    case (mode)
      MODE_ALLOC: begin
        res.status = ST_FULL;
        for (int i = 0; i < n; i++) begin
          if (handle_table[i] == 32'd0) begin
            handle_table[i] = handle;
            res.granted = i[5:0];
            res.status = ST_OK;
            break;
          end
        end
      end
      MODE_GET: begin
        if (in_range) res.value = handle_table[idx[IDX_W-1:0]];
        else res.status = ST_RANGE;
      end
      MODE_RELEASE: begin
        if (in_range) handle_table[idx[IDX_W-1:0]] = 32'd0;
        else res.status = ST_RANGE;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic slot_req_t make_req(logic [1:0] mode, logic signed [7:0] idx,
                                         logic [31:0] handle);
    slot_req_t r;
    r.mode = mode;
    r.slot_index = idx;
    r.handle = handle;
    return r;
  endfunction

  // Random request biased toward valid indices so the table fills and drains.
  function automatic slot_req_t random_req();
    slot_req_t r;
    int n;
    int pick;
    n = active_slots();
    pick = $urandom_range(99);
    r.handle = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
    r.slot_index = 8'($urandom_range(255));
    if (pick < 40) r.mode = MODE_ALLOC;
    else if (pick < 65) r.mode = MODE_GET;
    else if (pick < 90) r.mode = MODE_RELEASE;
    else if (pick < 95) r.mode = MODE_UNUSED;
    else r.mode = 2'($urandom_range(2));
    pick = $urandom_range(9);
    if (pick < 8) begin
      r.slot_index = 8'($urandom_range(n > 0 ? n - 1 : 0));
    end else if (pick == 8) begin
      case ($urandom_range(4))
        0: r.slot_index = 8'(n);
        1: r.slot_index = 8'((n > 0) ? n - 1 : 0);
        2: r.slot_index = 8'sd127;
        3: r.slot_index = -8'sd128;
        default: r.slot_index = -8'sd1;
      endcase
    end
    return r;
  endfunction

  // Driver: predicts each accepted transaction and presents the next pending one.
  always @(posedge clk) begin : request_driver
    slot_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(apply_slot_op(in_mode, in_slot_index, in_object_value));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_mode <= req.mode;
          in_slot_index <= req.slot_index;
          in_object_value <= req.handle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    slot_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction, status %0d granted %0d value %h",
                 $time, out_status, out_granted_index, out_read_value);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          fail_count++;
        end
        if (out_granted_index !== want.granted) begin
          $display("%0t: granted_index expected %0d actual %0d",
                   $time, want.granted, out_granted_index);
          fail_count++;
        end
        if (out_read_value !== want.value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.value, out_read_value);
          fail_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Waits until every transaction has been sent and answered, then lets the block settle.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_table_size(logic [6:0] size);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    table_size_model = size;
    @(negedge clk);
  endtask

  task automatic run_random_phase(logic [6:0] size, int idle_pct, int stall_pct, int count);
    write_table_size(size);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) pending_reqs.push_back(random_req());
  endtask

  initial begin
    foreach (handle_table[i]) handle_table[i] = 32'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed checks at the reset size: boundaries, zero handles, empty slots, no-op mode.
    pending_reqs.push_back(make_req(MODE_GET, 8'sd0, 32'd0));
    pending_reqs.push_back(make_req(MODE_ALLOC, -8'sd1, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(MODE_ALLOC, 8'sd0, 32'h0000_0001));
    pending_reqs.push_back(make_req(MODE_ALLOC, 8'sd5, 32'd0));
    pending_reqs.push_back(make_req(MODE_ALLOC, 8'sd0, 32'hA5A5_5A5A));
    pending_reqs.push_back(make_req(MODE_GET, 8'sd0, 32'd0));
    pending_reqs.push_back(make_req(MODE_GET, 8'sd2, 32'd0));
    pending_reqs.push_back(make_req(MODE_GET, 8'sd63, 32'd0));
    pending_reqs.push_back(make_req(MODE_GET, 8'sd64, 32'd0));
    pending_reqs.push_back(make_req(MODE_GET, 8'sd127, 32'd0));
    pending_reqs.push_back(make_req(MODE_GET, -8'sd1, 32'd0));
    pending_reqs.push_back(make_req(MODE_GET, -8'sd128, 32'd0));
    pending_reqs.push_back(make_req(MODE_RELEASE, 8'sd1, 32'd0));
    pending_reqs.push_back(make_req(MODE_RELEASE, 8'sd1, 32'd0));
    pending_reqs.push_back(make_req(MODE_RELEASE, -8'sd1, 32'd0));
    pending_reqs.push_back(make_req(MODE_RELEASE, 8'sd64, 32'd0));
    pending_reqs.push_back(make_req(MODE_ALLOC, 8'sd0, 32'h1234_5678));
    pending_reqs.push_back(make_req(MODE_UNUSED, -8'sd1, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(MODE_RELEASE, 8'sd63, 32'd0));

    // A zero size rejects everything; a size of one fills at once.
    write_table_size(7'd0);
    pending_reqs.push_back(make_req(MODE_ALLOC, 8'sd0, 32'h0000_00FF));
    pending_reqs.push_back(make_req(MODE_GET, 8'sd0, 32'd0));
    pending_reqs.push_back(make_req(MODE_RELEASE, 8'sd0, 32'd0));
    write_table_size(7'd1);
    pending_reqs.push_back(make_req(MODE_ALLOC, 8'sd0, 32'hDEAD_0001));
    pending_reqs.push_back(make_req(MODE_RELEASE, 8'sd0, 32'd0));
    pending_reqs.push_back(make_req(MODE_ALLOC, 8'sd0, 32'hDEAD_0002));

    // Random phases across sizes, including saturation above the depth, and idle patterns.
    run_random_phase(7'd64, 0, 0, 200);
    run_random_phase(7'd4, 78, 0, 150);
    run_random_phase(7'd127, 0, 78, 200);
    run_random_phase(7'd1, 27, 27, 100);
    run_random_phase(7'd33, 27, 27, 150);
    run_random_phase(7'd0, 0, 0, 30);
    run_random_phase(7'd65, 78, 78, 120);

    wait_idle();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("** slot_table_allocator: PASSED **");
    end else begin
      $display("** slot_table_allocator: FAILED **");
    end
    $finish;
  end

  // Watchdog in case the block hangs.
  initial begin
    #5_000_000;
    $display("** slot_table_allocator: FAILED **");
    $finish;
  end

endmodule
